// ----- src/fbf_pkg.sv -----
// package: shared types and constants of the flow controlled byte fifo
package fbf_pkg;

  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned MAX_BURST_DEF = 64;

  localparam int unsigned CAP_W  = 11;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned TOT_W  = 48;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam int unsigned      CAP_MAX   = 2047;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_END   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              accepted;
    logic              last;
    logic [CAP_W-1:0]  occupancy;
    logic [CAP_W-1:0]  space_left;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
    logic              ended;
    logic              at_eof;
  } res_t;

endpackage

// ----- src/flow_controlled_byte_fifo_core.sv -----
// top level: bounded byte fifo with flow control, status on every result
// usage:
//   input channel (in_valid_i/in_ready_o) takes one transaction: write byte,
//   read and pop, peek, or end input. output channel (out_valid_o/out_ready_i)
//   returns results; write, end and empty requests give one result, a read or
//   peek of n bytes gives n results with last_o on the final one.
//   cfg_we_i writes the capacity register; do so only while the block is idle.
// path: a write, end or empty result is registered in the read stage, then in
//   the result queue; a read or peek issues its bytes from the burst state.
// issue: write, end and empty requests are taken back to back; a read or peek
//   of n bytes issues one ring memory read per cycle while results have room,
//   and the next transaction is taken only after its last byte is issued.
// reset: pointers, fill level, totals and the ended flag clear, capacity
//   returns to 1024; the ring memory is not cleared.
// stall: a two-entry result queue plus the read stage absorb the memory
//   latency; issue stops and in_ready_o drops when two results wait unpopped.
module flow_controlled_byte_fifo_core #(
  parameter int unsigned DEPTH     = fbf_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = fbf_pkg::MAX_BURST_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbf_pkg::CAP_W-1:0]   cfg_capacity_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fbf_pkg::OP_W-1:0]    op_i,
  input  logic [fbf_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [fbf_pkg::CNT_W-1:0]   count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fbf_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        accepted_o,
  output logic                        last_o,
  output logic [fbf_pkg::CAP_W-1:0]   occupancy_o,
  output logic [fbf_pkg::CAP_W-1:0]   space_left_o,
  output logic [fbf_pkg::TOT_W-1:0]   total_written_o,
  output logic [fbf_pkg::TOT_W-1:0]   total_read_o,
  output logic                        ended_o,
  output logic                        at_eof_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                       issue_ok;
  logic                       iss_valid;
  fbf_pkg::res_t              iss_res;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [fbf_pkg::BYTE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [fbf_pkg::BYTE_W-1:0] mem_rdata;

  logic                       s1_valid_q;
  fbf_pkg::res_t              s1_res_q;
  fbf_pkg::res_t              push_res;
  logic                       pop;
  logic [1:0]                 oq_cnt;
  fbf_pkg::res_t              oq_res;

  fbf_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST),
    .AW        (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .count_i        (count_i),
    .issue_ok_i     (issue_ok),
    .iss_valid_o    (iss_valid),
    .iss_res_o      (iss_res),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr)
  );

  fbf_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // read stage registers the result alongside the registered ram read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= iss_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_valid) begin
      s1_res_q <= iss_res;
    end
  end

  always_comb begin
    push_res          = s1_res_q;
    push_res.out_byte = s1_res_q.byte_valid ? mem_rdata : '0;
  end

  assign pop      = out_valid_o && out_ready_i;
  assign issue_ok = pop || (oq_cnt == 2'd0) || ((oq_cnt == 2'd1) && !s1_valid_q);

  fbf_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_valid_q),
    .push_res_i (push_res),
    .pop_i      (pop),
    .valid_o    (out_valid_o),
    .res_o      (oq_res),
    .cnt_o      (oq_cnt)
  );

  assign out_byte_o      = oq_res.out_byte;
  assign byte_valid_o    = oq_res.byte_valid;
  assign accepted_o      = oq_res.accepted;
  assign last_o          = oq_res.last;
  assign occupancy_o     = oq_res.occupancy;
  assign space_left_o    = oq_res.space_left;
  assign total_written_o = oq_res.total_written;
  assign total_read_o    = oq_res.total_read;
  assign ended_o         = oq_res.ended;
  assign at_eof_o        = oq_res.at_eof;

endmodule

// ----- src/fbf_ram.sv -----
// ring storage: one write port and one registered read port
module fbf_ram #(
  parameter int unsigned DEPTH = fbf_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(fbf_pkg::DEPTH_DEF)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [fbf_pkg::BYTE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [fbf_pkg::BYTE_W-1:0] rdata_o
);

  logic [fbf_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [fbf_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fbf_outq.sv -----
// two-entry result queue in front of the output channel
module fbf_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fbf_pkg::res_t push_res_i,
  input  logic          pop_i,
  output logic          valid_o,
  output fbf_pkg::res_t res_o,
  output logic [1:0]    cnt_o
);

  fbf_pkg::res_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_res_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = slot_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

endmodule

// ----- src/fbf_ctrl.sv -----
// sequencer: fifo state, transaction decode and per-byte read issue
module fbf_ctrl #(
  parameter int unsigned DEPTH     = fbf_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = fbf_pkg::MAX_BURST_DEF,
  parameter int unsigned AW        = $clog2(fbf_pkg::DEPTH_DEF)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbf_pkg::CAP_W-1:0]   cfg_capacity_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fbf_pkg::OP_W-1:0]    op_i,
  input  logic [fbf_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [fbf_pkg::CNT_W-1:0]   count_i,
  input  logic                        issue_ok_i,
  output logic                        iss_valid_o,
  output fbf_pkg::res_t               iss_res_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [fbf_pkg::BYTE_W-1:0]  mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o
);

  localparam int unsigned DEPTH_SAT = (DEPTH > fbf_pkg::CAP_MAX) ? fbf_pkg::CAP_MAX : DEPTH;
  localparam logic [fbf_pkg::CAP_W-1:0] EFF_MAX = fbf_pkg::CAP_W'(DEPTH_SAT);
  localparam logic [fbf_pkg::CNT_W-1:0] BURST_MAX = fbf_pkg::CNT_W'(MAX_BURST);

  fbf_pkg::state_e state_q, state_d;

  logic [AW-1:0]               head_q, head_d;
  logic [AW-1:0]               tail_q, tail_d;
  logic [AW-1:0]               ptr_q, ptr_d;
  logic [fbf_pkg::CAP_W-1:0]   fill_q, fill_d;
  logic [fbf_pkg::CAP_W-1:0]   cap_q, cap_d;
  logic [fbf_pkg::TOT_W-1:0]   wtot_q, wtot_d;
  logic [fbf_pkg::TOT_W-1:0]   rtot_q, rtot_d;
  logic                        done_q, done_d;
  logic                        peek_q, peek_d;
  logic [fbf_pkg::CNT_W-1:0]   rem_q, rem_d;

  fbf_pkg::op_e                op;
  logic                        in_acc;
  logic [fbf_pkg::CAP_W-1:0]   eff_cap;
  logic [fbf_pkg::CNT_W-1:0]   cnt_clamp;
  logic [fbf_pkg::CAP_W-1:0]   cnt_fill;
  logic [fbf_pkg::CNT_W-1:0]   burst_len;
  logic                        is_fetch;
  logic                        acc;
  logic                        bvalid;
  logic                        last;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign op         = fbf_pkg::op_e'(op_i);
  assign in_ready_o = (state_q == fbf_pkg::ST_IDLE) && issue_ok_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign eff_cap    = (cap_q > EFF_MAX) ? EFF_MAX : cap_q;
  assign cnt_clamp  = (count_i > BURST_MAX) ? BURST_MAX : count_i;
  assign cnt_fill   = (fbf_pkg::CAP_W'(cnt_clamp) > fill_q) ? fill_q
                                                            : fbf_pkg::CAP_W'(cnt_clamp);
  assign burst_len  = cnt_fill[fbf_pkg::CNT_W-1:0];
  assign is_fetch   = (op == fbf_pkg::OP_READ) || (op == fbf_pkg::OP_PEEK);
  assign cap_d      = cfg_we_i ? cfg_capacity_i : cap_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbf_pkg::ST_IDLE: begin
        if (in_acc && is_fetch && (burst_len != '0)) begin
          state_d = fbf_pkg::ST_BURST;
        end
      end
      fbf_pkg::ST_BURST: begin
        if (issue_ok_i && (rem_q == fbf_pkg::CNT_W'(1))) begin
          state_d = fbf_pkg::ST_IDLE;
        end
      end
      default: state_d = fbf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    wtot_d      = wtot_q;
    rtot_d      = rtot_q;
    done_d      = done_q;
    peek_d      = peek_q;
    rem_d       = rem_q;
    iss_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    acc         = 1'b0;
    bvalid      = 1'b0;
    last        = 1'b1;
    unique case (state_q)
      fbf_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            fbf_pkg::OP_WRITE: begin
              iss_valid_o = 1'b1;
              if (fill_q < eff_cap) begin
                mem_we_o = 1'b1;
                tail_d   = ptr_inc(tail_q);
                fill_d   = fill_q + fbf_pkg::CAP_W'(1);
                wtot_d   = wtot_q + fbf_pkg::TOT_W'(1);
                acc      = 1'b1;
              end
            end
            fbf_pkg::OP_END: begin
              iss_valid_o = 1'b1;
              done_d      = 1'b1;
            end
            fbf_pkg::OP_READ, fbf_pkg::OP_PEEK: begin
              if (burst_len == '0) begin
                iss_valid_o = 1'b1;
              end else begin
                rem_d  = burst_len;
                ptr_d  = head_q;
                peek_d = (op == fbf_pkg::OP_PEEK);
              end
            end
            default: iss_valid_o = 1'b0;
          endcase
        end
      end
      fbf_pkg::ST_BURST: begin
        if (issue_ok_i) begin
          iss_valid_o = 1'b1;
          mem_re_o    = 1'b1;
          bvalid      = 1'b1;
          last        = (rem_q == fbf_pkg::CNT_W'(1));
          ptr_d       = ptr_inc(ptr_q);
          rem_d       = rem_q - fbf_pkg::CNT_W'(1);
          if (!peek_q) begin
            head_d = ptr_inc(ptr_q);
            fill_d = fill_q - fbf_pkg::CAP_W'(1);
            rtot_d = rtot_q + fbf_pkg::TOT_W'(1);
          end
        end
      end
      default: iss_valid_o = 1'b0;
    endcase
  end

  // status after this transaction's update
  always_comb begin
    iss_res_o               = '0;
    iss_res_o.byte_valid    = bvalid;
    iss_res_o.accepted      = acc;
    iss_res_o.last          = last;
    iss_res_o.occupancy     = fill_d;
    iss_res_o.space_left    = (fill_d < eff_cap) ? eff_cap - fill_d : '0;
    iss_res_o.total_written = wtot_d;
    iss_res_o.total_read    = rtot_d;
    iss_res_o.ended         = done_d;
    iss_res_o.at_eof        = done_d && (fill_d == '0);
  end

  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = data_byte_i;
  assign mem_raddr_o = ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbf_pkg::ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      ptr_q   <= '0;
      fill_q  <= '0;
      cap_q   <= fbf_pkg::CAP_RESET;
      wtot_q  <= '0;
      rtot_q  <= '0;
      done_q  <= 1'b0;
      peek_q  <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      cap_q   <= cap_d;
      wtot_q  <= wtot_d;
      rtot_q  <= rtot_d;
      done_q  <= done_d;
      peek_q  <= peek_d;
      rem_q   <= rem_d;
    end
  end

  a_burst_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbf_pkg::ST_BURST) |-> (rem_q != '0))
    else $error("burst with no bytes left");

  a_burst_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fbf_pkg::ST_BURST) |-> (fbf_pkg::CAP_W'(rem_q) <= fill_q))
    else $error("burst longer than buffered bytes");

  a_issue_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_valid_o |-> issue_ok_i)
    else $error("result issued without room");

  a_burst_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == fbf_pkg::ST_BURST) && issue_ok_i && (rem_q == fbf_pkg::CNT_W'(1)))
      |=> (state_q == fbf_pkg::ST_IDLE))
    else $error("burst did not end after last byte");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fill_q) <= DEPTH))
    else $error("fill level above depth");

endmodule
